// ===== rtl/salru_pkg.sv =====
// shared types and constants for the set-associative lru tag cache
// no dependencies; imported by every module of the block
package salru_pkg;

    // apb register map, word index = paddr[3:2]
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_WAYS_USED  = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_STORE  = 2'd1,
        OP_MODIFY = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] address;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic        miss;
        logic        evicted;
        logic        last;
        logic [31:0] hits_total;
        logic [31:0] misses_total;
        logic [31:0] evictions_total;
    } t_out_word;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [3:0] ways_used;
        logic [5:0] block_bits;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOKUP,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic read;
        logic lookup;
        logic scan_step;
        logic update;
        logic clear_step;
        logic last;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_done;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/salru_ctrl.sv =====
// sequencer for the lru tag cache: clear pass, read, lookup, lru scan, update
// depends on salru_pkg
module salru_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  salru_pkg::t_op       i_op,
    input  salru_pkg::t_dp_stat  i_stat,
    output salru_pkg::t_ctrl_cmd o_cmd,
    output logic                 o_in_stall
);
    import salru_pkg::*;

    t_state r_state, n_state;
    logic   r_first, n_first;   // first of the two accesses of a modify

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_first    = r_first;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                // unused op code is taken and dropped
                if (i_in_valid && (i_op != OP_NONE)) begin
                    o_cmd.capture = 1'b1;
                    n_first       = (i_op == OP_MODIFY);
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = i_stat.need_scan ? ST_SCAN : ST_UPDATE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.last = !r_first;
                if (i_stat.out_free) begin
                    o_cmd.update = 1'b1;
                    if (r_first) begin
                        n_first = 1'b0;
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/salru_dp.sv =====
// datapath for the lru tag cache: address split, set memory, tag compare,
// lru scan, stamp and saturating tallies, output word register
// depends on salru_pkg
module salru_dp #(
    parameter int SET_BITS_MAX = 6,
    parameter int WAYS_MAX     = 8,
    parameter int ADDR_BITS    = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  salru_pkg::t_cfg      i_cfg,
    input  salru_pkg::t_in_word  i_in_word,
    input  salru_pkg::t_ctrl_cmd i_cmd,
    output salru_pkg::t_dp_stat  o_stat,
    output logic                 o_out_valid,
    output salru_pkg::t_out_word o_out_word,
    input  logic                 i_out_stall
);
    import salru_pkg::*;

    localparam int NUM_SETS = 1 << SET_BITS_MAX;
    localparam int SET_W    = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
    localparam int WAY_W    = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
    localparam int NW_W     = $clog2(WAYS_MAX + 1);

    // set memory, one row per set
    logic [WAYS_MAX-1:0]  mem_valid [NUM_SETS];
    logic [ADDR_BITS-1:0] mem_tag   [NUM_SETS][WAYS_MAX];
    logic [63:0]          mem_stamp [NUM_SETS][WAYS_MAX];

    // registered row
    logic [WAYS_MAX-1:0]  r_rd_valid;
    logic [ADDR_BITS-1:0] r_rd_tag   [WAYS_MAX];
    logic [63:0]          r_rd_stamp [WAYS_MAX];

    logic [SET_W-1:0]     r_set;
    logic [ADDR_BITS-1:0] r_key;
    logic [SET_W-1:0]     r_clr;
    logic                 r_hit;
    logic                 r_evict;
    logic [WAY_W-1:0]     r_way;
    logic [WAY_W-1:0]     r_cnt;
    logic [63:0]          r_best;
    logic [63:0]          r_stamp;
    logic [31:0]          r_hits, r_misses, r_evicts;
    logic                 r_out_valid;
    t_out_word            r_out;

    logic [ADDR_BITS-1:0] sp_addr, sp_rest, sp_key;
    logic [2:0]           sp_sb;
    logic [SET_W-1:0]     sp_mask, sp_set;
    logic [NW_W-1:0]      nw;
    logic [WAYS_MAX-1:0]  lk_match, lk_inv, way_onehot;
    logic [WAY_W-1:0]     lk_hit_way, lk_inv_way;
    logic                 lk_hit, lk_any_inv;
    logic [63:0]          n_stamp;
    logic [31:0]          n_hits, n_misses, n_evicts;
    logic                 out_free;

    // address split: offset dropped, set index, key above it
    always_comb begin
        sp_addr = i_in_word.address[ADDR_BITS-1:0];
        sp_rest = sp_addr >> i_cfg.block_bits;
        sp_sb   = (32'(i_cfg.set_bits) > SET_BITS_MAX) ? 3'(SET_BITS_MAX) : i_cfg.set_bits;
        sp_mask = ~({SET_W{1'b1}} << sp_sb);
        sp_set  = sp_rest[SET_W-1:0] & sp_mask;
        sp_key  = sp_rest >> sp_sb;
    end

    always_comb begin
        if (i_cfg.ways_used == 4'd0) begin
            nw = NW_W'(1);
        end else if (32'(i_cfg.ways_used) > WAYS_MAX) begin
            nw = NW_W'(WAYS_MAX);
        end else begin
            nw = NW_W'(i_cfg.ways_used);
        end
    end

    // parallel tag compare over the ways in use
    always_comb begin
        lk_match = '0;
        lk_inv   = '0;
        for (int w = 0; w < WAYS_MAX; w++) begin
            if (NW_W'(w) < nw) begin
                lk_match[w] = r_rd_valid[w] && (r_rd_tag[w] == r_key);
                lk_inv[w]   = !r_rd_valid[w];
            end
        end
        // lowest matching way wins
        lk_hit_way = '0;
        for (int w = WAYS_MAX - 1; w >= 0; w--) begin
            if (lk_match[w]) begin
                lk_hit_way = WAY_W'(w);
            end
        end
        // highest invalid way is filled
        lk_inv_way = '0;
        for (int w = 0; w < WAYS_MAX; w++) begin
            if (lk_inv[w]) begin
                lk_inv_way = WAY_W'(w);
            end
        end
        lk_hit     = |lk_match;
        lk_any_inv = |lk_inv;
    end

    always_comb begin
        way_onehot        = '0;
        way_onehot[r_way] = 1'b1;
    end

    assign n_stamp  = r_stamp + 64'd1;
    assign n_hits   = (r_hit && (r_hits != '1)) ? r_hits + 32'd1 : r_hits;
    assign n_misses = (!r_hit && (r_misses != '1)) ? r_misses + 32'd1 : r_misses;
    assign n_evicts = (r_evict && (r_evicts != '1)) ? r_evicts + 32'd1 : r_evicts;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.clear_done = (r_clr == SET_W'(NUM_SETS - 1));
    assign o_stat.need_scan  = !lk_hit && !lk_any_inv && (nw > NW_W'(1));
    assign o_stat.scan_done  = (NW_W'(r_cnt) == (nw - NW_W'(1)));
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            mem_valid[r_clr] <= '0;
        end else if (i_cmd.update && !r_hit) begin
            mem_valid[r_set] <= r_rd_valid | way_onehot;
        end
        if (i_cmd.update && !r_hit) begin
            mem_tag[r_set][r_way] <= r_key;
        end
        if (i_cmd.update) begin
            mem_stamp[r_set][r_way] <= n_stamp;
        end
        if (i_cmd.read) begin
            r_rd_valid <= mem_valid[r_set];
            r_rd_tag   <= mem_tag[r_set];
            r_rd_stamp <= mem_stamp[r_set];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_stamp     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
                r_stamp     <= n_stamp;
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_evicts    <= n_evicts;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_set <= sp_set;
            r_key <= sp_key;
        end
        if (i_cmd.lookup) begin
            r_hit   <= lk_hit;
            r_evict <= !lk_hit && !lk_any_inv;
            r_way   <= lk_hit ? lk_hit_way : (lk_any_inv ? lk_inv_way : '0);
            r_best  <= r_rd_stamp[0];
            r_cnt   <= WAY_W'(1);
        end else if (i_cmd.scan_step) begin
            if (r_rd_stamp[r_cnt] < r_best) begin
                r_best <= r_rd_stamp[r_cnt];
                r_way  <= r_cnt;
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.update) begin
            r_out.hit             <= r_hit;
            r_out.miss            <= !r_hit;
            r_out.evicted         <= r_evict;
            r_out.last            <= i_cmd.last;
            r_out.hits_total      <= n_hits;
            r_out.misses_total    <= n_misses;
            r_out.evictions_total <= n_evicts;
        end
    end

endmodule

// ===== rtl/set_assoc_lru_cache_tag_sim.sv =====
// top level of the set-associative lru tag cache: apb registers, sequencer, datapath
// depends on salru_pkg, salru_ctrl, salru_dp
//
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+------------------------------
// in      | input     | i_in_valid / o_in_stall   | i_in_word  (op, address)
// out     | output    | o_out_valid / i_out_stall | o_out_word (flags and totals)
// cfg     | input     | psel penable pwrite pready| paddr, pwdata, prdata
//
// an access takes read, lookup and update cycles, one set read per access;
// a miss on a full set with more than one way in use adds an lru scan through the row
// load or store is one access, modify two; a new word is taken only once the last is done
// after reset a clearing pass over every set zeroes the valid bits
// the update cycle waits while the previous out word is still stalled
module set_assoc_lru_cache_tag_sim #(
    parameter int SET_BITS_MAX = 6,
    parameter int WAYS_MAX     = 8,
    parameter int ADDR_BITS    = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  salru_pkg::t_in_word                  i_in_word,
    // output words
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output salru_pkg::t_out_word                 o_out_word,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [salru_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [salru_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [salru_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);
    import salru_pkg::*;

    t_cfg      r_cfg;
    t_ctrl_cmd cmd;
    t_dp_stat  stat;
    logic      cfg_wr;

    // register file, writes complete in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= 3'd0;
            r_cfg.ways_used  <= 4'd1;
            r_cfg.block_bits <= 6'd0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SET_BITS:   r_cfg.set_bits   <= pwdata[2:0];
                REG_WAYS_USED:  r_cfg.ways_used  <= pwdata[3:0];
                REG_BLOCK_BITS: r_cfg.block_bits <= pwdata[5:0];
                default: begin
                    // unmapped word, write ignored
                end
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        unique case (paddr[3:2])
            REG_SET_BITS:   prdata = APB_DATA_W'(r_cfg.set_bits);
            REG_WAYS_USED:  prdata = APB_DATA_W'(r_cfg.ways_used);
            REG_BLOCK_BITS: prdata = APB_DATA_W'(r_cfg.block_bits);
            default:        prdata = '0;
        endcase
    end

    // sequencer: one access at a time, modify runs the access twice
    salru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_word.op),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // set memory, compare, lru scan and output word register
    salru_dp #(
        .SET_BITS_MAX (SET_BITS_MAX),
        .WAYS_MAX     (WAYS_MAX),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    // a new result never overwrites a word still waiting on the out side
    a_update_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |-> (!o_out_valid || !i_out_stall))
        else $error("result written over a pending out word");

    // every update shows up as a valid out word on the next cycle
    a_update_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |=> o_out_valid)
        else $error("update did not produce an out word");

    // each access is either a hit or a miss, and only a miss evicts
    a_hit_xor_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.hit != o_out_word.miss)
                         && (!o_out_word.evicted || o_out_word.miss)))
        else $error("inconsistent hit, miss and eviction flags");

    // no input is taken in the read, lookup or scan step of an access or during the clear pass
    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.read || cmd.lookup || cmd.scan_step || cmd.clear_step) |-> o_in_stall)
        else $error("input accepted while busy");

endmodule

// ===== bench/tb_set_assoc_lru_cache_tag_sim.sv =====
// testbench for the set-associative lru tag cache: directed and random words,
// checked against an in-bench tag store with lru stamps and saturating totals
// depends on salru_pkg and set_assoc_lru_cache_tag_sim
module tb_set_assoc_lru_cache_tag_sim;
    import salru_pkg::*;

    localparam int SET_BITS_MAX   = 6;
    localparam int WAYS_MAX       = 8;
    localparam int ADDR_BITS      = 64;
    localparam int NUM_LINES      = (1 << SET_BITS_MAX) * WAYS_MAX;
    // the longest access is a modify with two full lru scans
    localparam int SETTLE_CYCLES  = 40;
    // cycles with no word and no register write moving before giving up
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_WORDS    = 175;
    localparam int NUM_PHASES     = 10;
    localparam int PRINT_CAP      = 40;

    // clock, reset and block ports
    logic                  i_clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  out_stall = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_word;

    // no idling on either side while this is set
    bit steady = 1'b0;
    int unsigned mismatch_count = 0;

    // bench copy of the tag store, the stamps and the register settings
    bit          line_valid_q [NUM_LINES];
    bit [63:0]   line_key_q   [NUM_LINES];
    bit [63:0]   line_age_q   [NUM_LINES];
    bit [63:0]   use_clock    = '0;
    bit [31:0]   hits_so_far   = '0;
    bit [31:0]   misses_so_far = '0;
    bit [31:0]   evict_count  = '0;
    logic [2:0]  cfg_set_bits   = 3'd0;
    logic [3:0]  cfg_ways       = 4'd1;
    logic [5:0]  cfg_block_bits = 6'd0;

    // out words still owed by the block, oldest first
    t_out_word access_results_q [$];

    set_assoc_lru_cache_tag_sim #(
        .SET_BITS_MAX (SET_BITS_MAX),
        .WAYS_MAX     (WAYS_MAX),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // effective set index width and associativity after clamping
    function automatic int unsigned eff_set_bits(input logic [2:0] sb);
        return (sb > SET_BITS_MAX) ? SET_BITS_MAX : sb;
    endfunction

    function automatic int unsigned eff_ways(input logic [3:0] nw);
        return (nw == 0) ? 1 : ((nw > WAYS_MAX) ? WAYS_MAX : nw);
    endfunction

    function automatic bit [31:0] sat_bump(input bit [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // one access: split the address, search the set, refresh or fill, count
    function automatic t_out_word tag_lookup_fill(input logic [63:0] addr,
                                                  input logic is_last);
        int unsigned sb;
        int unsigned nw;
        int unsigned base;
        int unsigned pick;
        int unsigned idx;
        logic [63:0] rest;
        logic [63:0] key;
        logic        found;
        t_out_word   r;
        sb    = eff_set_bits(cfg_set_bits);
        nw    = eff_ways(cfg_ways);
        // shifts of the full width or more leave zero, as wanted for the key
        rest  = addr >> cfg_block_bits;
        key   = rest >> sb;
        base  = int'(rest & ((64'd1 << sb) - 64'd1)) * WAYS_MAX;
        pick  = base;
        found = 1'b0;
        r     = '0;
        use_clock = use_clock + 64'd1;
        for (int w = 0; w < nw; w++) begin
            if (!found) begin
                idx = base + w;
                if (line_valid_q[idx] && line_key_q[idx] == key) begin
                    found           = 1'b1;
                    line_age_q[idx] = use_clock;
                end else if (!line_valid_q[idx] ||
                             (line_valid_q[pick] && line_age_q[idx] < line_age_q[pick])) begin
                    // later invalid ways win, older stamps win, ties keep the lower way
                    pick = idx;
                end
            end
        end
        if (found) begin
            hits_so_far = sat_bump(hits_so_far);
        end else begin
            misses_so_far = sat_bump(misses_so_far);
            if (line_valid_q[pick]) begin
                r.evicted   = 1'b1;
                evict_count = sat_bump(evict_count);
            end
            line_valid_q[pick] = 1'b1;
            line_key_q[pick]   = key;
            line_age_q[pick]   = use_clock;
        end
        r.hit             = found;
        r.miss            = !found;
        r.last            = is_last;
        r.hits_total      = hits_so_far;
        r.misses_total    = misses_so_far;
        r.evictions_total = evict_count;
        return r;
    endfunction

    // queue the out words that one accepted in word owes
    task automatic enqueue_accesses(input t_in_word w);
        case (w.op)
            OP_LOAD, OP_STORE: begin
                access_results_q.push_back(tag_lookup_fill(w.address, 1'b1));
            end
            OP_MODIFY: begin
                access_results_q.push_back(tag_lookup_fill(w.address, 1'b0));
                access_results_q.push_back(tag_lookup_fill(w.address, 1'b1));
            end
            default: begin
                // unused op code: no access, no out word
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", field, got, want));
    endtask

    // checker on the out channel; the receiver stall is redrawn every cycle
    always @(posedge i_clk) begin
        t_out_word want;
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (access_results_q.size() == 0) begin
                report_mismatch("out word with nothing pending");
            end else begin
                want = access_results_q.pop_front();
                check_field("hit",     32'(o_out_word.hit),     32'(want.hit));
                check_field("miss",    32'(o_out_word.miss),    32'(want.miss));
                check_field("evicted", 32'(o_out_word.evicted), 32'(want.evicted));
                check_field("last",    32'(o_out_word.last),    32'(want.last));
                check_field("hits_total",      o_out_word.hits_total,      want.hits_total);
                check_field("misses_total",    o_out_word.misses_total,    want.misses_total);
                check_field("evictions_total", o_out_word.evictions_total,
                            want.evictions_total);
            end
        end
        out_stall <= !steady && ($urandom_range(0, 99) < 35);
    end

    // watchdog: any moved word or register write counts as progress
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !out_stall) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_set_assoc_lru_cache_tag_sim NOT OK");
        $finish;
    end

    // send one in word, with random gaps ahead of it; valid is left high
    // after the accept so a back-to-back word never drops it
    task automatic send_word(input t_op op, input logic [63:0] addr);
        while (!steady && $urandom_range(0, 99) < 35) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{op: op, address: addr};
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        enqueue_accesses(in_word);
    endtask

    // hold the sender until every owed out word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (access_results_q.size() != 0);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_SET_BITS:   cfg_set_bits   = value[2:0];
            REG_WAYS_USED:  cfg_ways       = value[3:0];
            REG_BLOCK_BITS: cfg_block_bits = value[5:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // new register settings only once the block has gone quiet, with some
    // idle cycles before the writes
    task automatic configure(input logic [2:0] sb, input logic [3:0] ways,
                             input logic [5:0] bb);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_SET_BITS,   {29'd0, sb});
        write_reg(REG_WAYS_USED,  {28'd0, ways});
        write_reg(REG_BLOCK_BITS, {26'd0, bb});
    endtask

    // reset settings: one set of one line, so every new key after the first evicts
    task automatic test_reset_defaults();
        send_word(OP_LOAD,   64'h0);
        send_word(OP_LOAD,   64'h0);
        send_word(OP_STORE,  '1);
        send_word(OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(OP_NONE,   64'h0);
        send_word(OP_LOAD,   '1);
        send_word(OP_STORE,  64'h5555_5555_5555_5555);
    endtask

    // four ways in one set: fill order, hit refresh, lru victim choice
    task automatic test_lru_order();
        configure(3'd2, 4'd4, 6'd4);
        for (int t = 1; t <= 4; t++)
            send_word(OP_LOAD, (64'(t) << 6) | 64'h10);
        send_word(OP_LOAD,   (64'd1 << 6) | 64'h13);
        // key 2 is now the oldest
        send_word(OP_STORE,  (64'd5 << 6) | 64'h10);
        send_word(OP_LOAD,   (64'd2 << 6) | 64'h10);
        send_word(OP_MODIFY, (64'd3 << 6) | 64'h1F);
        // offset bits must not matter
        send_word(OP_LOAD,   (64'd5 << 6) | 64'h1A);
    endtask

    // out-of-range registers and shifts that push the key off the top
    task automatic test_wide_shifts();
        configure(3'd7, 4'd0, 6'd63);
        send_word(OP_LOAD,   '1);
        send_word(OP_LOAD,   64'h8000_0000_0000_0000);
        send_word(OP_LOAD,   64'h0);
        // lines stay across the register change
        configure(3'd0, 4'd15, 6'd32);
        send_word(OP_LOAD,   64'hFFFF_FFFF_0000_0000);
        send_word(OP_STORE,  64'h0000_0001_FFFF_FFFF);
        send_word(OP_MODIFY, 64'hFFFF_FFFF_1234_5678);
    endtask

    // random phases: each picks settings, then mostly reuses a few sets and
    // keys so hits, fills and evictions all happen, with some raw addresses
    task automatic test_random_phases();
        logic [2:0]  sb_reg;
        logic [3:0]  ways_reg;
        logic [5:0]  bb_reg;
        int unsigned sb_eff;
        int unsigned n_keys;
        int unsigned roll;
        logic [63:0] keys [16];
        logic [63:0] sets [6];
        logic [63:0] addr;
        logic [63:0] offset_mask;
        t_op         op;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin sb_reg = 3'd6; ways_reg = 4'd8;  bb_reg = 6'd0;  end
                1: begin sb_reg = 3'd0; ways_reg = 4'd1;  bb_reg = 6'd63; end
                2: begin sb_reg = 3'd7; ways_reg = 4'd15; bb_reg = 6'd32; end
                3: begin sb_reg = 3'd6; ways_reg = 4'd0;  bb_reg = 6'd1;  end
                default: begin
                    sb_reg   = 3'($urandom_range(0, 7));
                    ways_reg = 4'($urandom_range(0, 15));
                    bb_reg   = 6'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                                             : $urandom_range(0, 63));
                end
            endcase
            configure(sb_reg, ways_reg, bb_reg);
            // one phase runs flat out on both sides
            steady      = (phase == 4);
            sb_eff      = eff_set_bits(sb_reg);
            n_keys      = eff_ways(ways_reg) + 3;
            offset_mask = (64'd1 << bb_reg) - 64'd1;
            for (int k = 0; k < n_keys; k++)
                keys[k] = $urandom_range(0, 1) ? 64'($urandom_range(0, 15))
                                               : {$urandom, $urandom};
            for (int s = 0; s < 6; s++)
                sets[s] = 64'($urandom_range(0, (1 << sb_eff) - 1));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // sender holds off until the block has caught up
                if ((phase == 0 && n == 60) || $urandom_range(0, 79) == 0)
                    drain_results();
                roll = $urandom_range(0, 99);
                op   = (roll < 30) ? OP_LOAD : (roll < 60) ? OP_STORE :
                       (roll < 95) ? OP_MODIFY : OP_NONE;
                if ($urandom_range(0, 99) < 15)
                    addr = {$urandom, $urandom};
                else
                    addr = (keys[$urandom_range(0, n_keys - 1)] << (bb_reg + sb_eff)) |
                           (sets[$urandom_range(0, 5)] << bb_reg) |
                           ({$urandom, $urandom} & offset_mask);
                send_word(op, addr);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        // hold reset, then the block clears its valid bits by itself
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_lru_order();
        test_wide_shifts();
        test_random_phases();
        drain_results();
        // leave time for any stray out word to show up
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && access_results_q.size() == 0) begin
            $display("tb_set_assoc_lru_cache_tag_sim OK");
        end else begin
            $display("tb_set_assoc_lru_cache_tag_sim NOT OK");
        end
        $finish;
    end

endmodule
